[hw/rtl/fls_pkg.sv]
// Shared constants, types and the tap coefficient table of the stereo lowpass FIR.
// Used by fls_tap_cell, fls_sum_tree and fir_lowpass_stereo_unit; depends on nothing.
package fls_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 14;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	// The coefficients add up to 32767, so every sum stays inside 31 signed bits.
	localparam int ACC_W         = PROD_W + 1;
	localparam int FRAC_W        = 15;
	localparam int TAP_COUNT_DEF = 10;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE   = CFG_IDX_W'(1);

	// RC lowpass taps for a 3000 Hz cutoff, normalized to unity DC gain, unsigned Q0.15 held in 14 bits.
	localparam logic [COEF_W-1:0] COEF_Q15 [TAP_COUNT_DEF] = '{
		COEF_W'(11558), COEF_W'(7538), COEF_W'(4916), COEF_W'(3206), COEF_W'(2091),
		COEF_W'(1364),  COEF_W'(889),  COEF_W'(580),  COEF_W'(378),  COEF_W'(247)
	};

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// Load enables of the pipeline stages behind the input.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Per-word side information that travels along the pipeline.
	typedef struct packed {
		logic    filt;
		logic    stereo;
		sample_t left;
		sample_t right;
	} side_t;

endpackage

[hw/rtl/fls_tap_cell.sv]
// One tap of a delay line: holds a sample, hands it to the next tap on a shift,
// and registers the product of its new sample with its coefficient. Uses fls_pkg.
module fls_tap_cell
	import fls_pkg::*;
#(
	parameter int TAP_IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  logic    load_en,
	input  sample_t sample_in,
	output sample_t hist,
	output prod_t   prod
);

	sample_t hist_q;
	sample_t hist_nxt;
	prod_t   prod_s1;
	prod_t   coef_ext;

	assign hist_nxt = shift_en ? sample_in : hist_q;
	assign coef_ext = $signed(PROD_W'(COEF_Q15[TAP_IDX]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift_en) begin
			hist_q <= sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			prod_s1 <= PROD_W'(hist_nxt) * coef_ext;
		end
	end

	assign hist = hist_q;
	assign prod = prod_s1;

endmodule

[hw/rtl/fls_sum_tree.sv]
// Registered adder tree that reduces the tap products of one channel to one sum
// over three stages. Uses fls_pkg.
module fls_sum_tree
	import fls_pkg::*;
#(
	parameter int TAP_COUNT = TAP_COUNT_DEF
) (
	input  logic      clk,
	input  stage_en_t en,
	input  prod_t     prod [TAP_COUNT],
	output acc_t      acc
);

	localparam int N2 = (TAP_COUNT + 1) / 2;
	localparam int N3 = (N2 + 1) / 2;

	acc_t sum_s2 [N2];
	acc_t sum_s3 [N3];
	acc_t acc_s4;
	acc_t acc_nxt;

	for (genvar j = 0; j < N2; j++) begin : g_s2
		if (2 * j + 1 < TAP_COUNT) begin : g_pair
			always_ff @(posedge clk) begin
				if (en.s2) begin
					sum_s2[j] <= ACC_W'(prod[2*j]) + ACC_W'(prod[2*j+1]);
				end
			end
		end else begin : g_single
			always_ff @(posedge clk) begin
				if (en.s2) begin
					sum_s2[j] <= ACC_W'(prod[2*j]);
				end
			end
		end
	end

	for (genvar j = 0; j < N3; j++) begin : g_s3
		if (2 * j + 1 < N2) begin : g_pair
			always_ff @(posedge clk) begin
				if (en.s3) begin
					sum_s3[j] <= sum_s2[2*j] + sum_s2[2*j+1];
				end
			end
		end else begin : g_single
			always_ff @(posedge clk) begin
				if (en.s3) begin
					sum_s3[j] <= sum_s2[2*j];
				end
			end
		end
	end

	always_comb begin
		acc_nxt = '0;
		for (int k = 0; k < N3; k++) begin
			acc_nxt = acc_nxt + sum_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			acc_s4 <= acc_nxt;
		end
	end

	assign acc = acc_s4;

endmodule

[hw/rtl/fir_lowpass_stereo_unit.sv]
// Ten-tap stereo RC lowpass FIR: a row of tap cells per channel, registered
// product and adder-tree stages, and an output register. Uses fls_pkg, fls_tap_cell
// and fls_sum_tree.
// Throughput: one frame per cycle unless the output stalls; each pipeline stage moves on
// as soon as its successor has room, so input is taken while a finished word waits at
// the output, as long as some stage is empty.
// Reset clears both delay lines to zero and sets filter_enable and stereo_mode to 1.
module fir_lowpass_stereo_unit
	import fls_pkg::*;
#(
	parameter int TAP_COUNT = TAP_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,   // [15:0] left_out, [31:16] right_out
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      filter_enable_q;
	logic      stereo_mode_q;
	logic      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic      en1, en5;
	stage_en_t en;
	logic      in_accept;
	logic      shift_en;
	side_t     side_in;
	side_t     side_s1, side_s2, side_s3, side_s4;
	sample_t   left_in, right_in;
	sample_t   hist_l [TAP_COUNT];
	sample_t   hist_r [TAP_COUNT];
	prod_t     prod_l [TAP_COUNT];
	prod_t     prod_r [TAP_COUNT];
	acc_t      acc_l, acc_r;
	sample_t   q_l, q_r;
	sample_t   left_out_nxt, right_out_nxt;
	sample_t   left_out_s5, right_out_s5;

	// Divide by 2^15 with truncation toward zero. The taps sum to just under one,
	// so the quotient always fits 16 bits and no saturation is needed.
	function automatic sample_t trunc_q15(input acc_t a);
		acc_t b;
		b = a + (a[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
		return b[ACC_W-1:FRAC_W];
	endfunction

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b1;
			stereo_mode_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				REG_STEREO_MODE:   stereo_mode_q   <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Stage flow control: a stage loads when it is empty or its content moves on.
	assign en5    = !v_s5 || m_axis_tready;
	assign en.s4  = !v_s4 || en5;
	assign en.s3  = !v_s3 || en.s4;
	assign en.s2  = !v_s2 || en.s3;
	assign en1    = !v_s1 || en.s2;

	assign s_axis_tready = en1;
	assign in_accept     = s_axis_tvalid && en1;
	assign shift_en      = in_accept && filter_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1)    v_s1 <= s_axis_tvalid;
			if (en.s2)  v_s2 <= v_s1;
			if (en.s3)  v_s3 <= v_s2;
			if (en.s4)  v_s4 <= v_s3;
			if (en5)    v_s5 <= v_s4;
		end
	end

	assign left_in  = s_axis_tdata[15:0];
	assign right_in = s_axis_tdata[31:16];

	assign side_in.filt   = filter_enable_q;
	assign side_in.stereo = stereo_mode_q;
	assign side_in.left   = left_in;
	assign side_in.right  = right_in;

	always_ff @(posedge clk) begin
		if (en1)   side_s1 <= side_in;
		if (en.s2) side_s2 <= side_s1;
		if (en.s3) side_s3 <= side_s2;
		if (en.s4) side_s4 <= side_s3;
	end

	// Delay lines: each cell takes the sample of its neighbor on a filtered word.
	for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
		sample_t l_src, r_src;
		if (i == 0) begin : g_head
			assign l_src = left_in;
			// In mono the right line takes in silence.
			assign r_src = stereo_mode_q ? right_in : sample_t'(0);
		end else begin : g_body
			assign l_src = hist_l[i-1];
			assign r_src = hist_r[i-1];
		end

		fls_tap_cell #(.TAP_IDX(i)) u_cell_l (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.load_en   (en1),
			.sample_in (l_src),
			.hist      (hist_l[i]),
			.prod      (prod_l[i])
		);

		fls_tap_cell #(.TAP_IDX(i)) u_cell_r (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.load_en   (en1),
			.sample_in (r_src),
			.hist      (hist_r[i]),
			.prod      (prod_r[i])
		);
	end

	fls_sum_tree #(.TAP_COUNT(TAP_COUNT)) u_tree_l (
		.clk  (clk),
		.en   (en),
		.prod (prod_l),
		.acc  (acc_l)
	);

	fls_sum_tree #(.TAP_COUNT(TAP_COUNT)) u_tree_r (
		.clk  (clk),
		.en   (en),
		.prod (prod_r),
		.acc  (acc_r)
	);

	// Output stage.
	assign q_l = trunc_q15(acc_l);
	assign q_r = trunc_q15(acc_r);

	always_comb begin
		left_out_nxt  = side_s4.filt ? q_l : side_s4.left;
		right_out_nxt = side_s4.filt ? q_r : side_s4.right;
		if (!side_s4.stereo) begin
			right_out_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			left_out_s5  <= left_out_nxt;
			right_out_s5 <= right_out_nxt;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {right_out_s5, left_out_s5};

	// Input is refused only when every stage holds a word and the output is stalled.
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_axis_tready))
		else $error("input blocked while the pipeline has room");

	// A bypassed word leaves the delay lines alone.
	a_bypass_keeps_history: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !filter_enable_q) |=> ($stable(hist_l[0]) && $stable(hist_r[0])))
		else $error("delay line moved on a bypassed word");

	// A filtered mono word pushes silence into the right delay line.
	a_mono_right_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && filter_enable_q && !stereo_mode_q) |=> (hist_r[0] == '0))
		else $error("right delay line took a sample in mono mode");

endmodule
